// ----- rtl/core/scanline_polygon_span_fill_core_defines.svh -----
// Assertion macros used by the span fill core top level.
`ifndef SCANLINE_POLYGON_SPAN_FILL_CORE_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SPF_ASSERT_IMP(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define SPF_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error(msg);
`endif

// ----- rtl/core/spf_pkg.sv -----
// Package: shared types and constants of the span fill core.
package spf_pkg;
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_ROW    = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_SPANS = 8;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BUILD_RD, ST_BUILD_EDGE, ST_DIV_WAIT, ST_BUILD_WR,
        ST_END_SCAN, ST_CHECK, ST_ROW_SCAN, ST_EMIT, ST_EMIT_WAIT,
        ST_UPDATE, ST_DONE_OUT
    } spf_state_t;

    // Divider handshake.
    typedef struct packed {
        logic start;
    } spf_div_ctl_t;
endpackage

// ----- rtl/core/spf_divider.sv -----
// Restoring divider: quotient of a dividend by a divisor, one bit per cycle.
module spf_divider
    import spf_pkg::*;
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  spf_div_ctl_t     ctl,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] q_reg, q_next;
    logic [DEN_W:0]   r_reg, r_next;
    logic [DEN_W-1:0] d_reg, d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W+1:0] sh;

    // Shift one dividend bit in and try the subtract.
    always_comb begin
        q_next   = q_reg;
        r_next   = r_reg;
        d_next   = d_reg;
        cnt_next = cnt_reg;
        sh       = {r_reg, q_reg[NUM_W-1]};
        trial    = '0;
        if (ctl.start) begin
            q_next   = num;
            r_next   = '0;
            d_next   = den;
            cnt_next = CNT_W'(NUM_W);
        end else if (cnt_reg != '0) begin
            if (sh >= {1'b0, 1'b0, d_reg}) begin
                trial  = (DEN_W+1)'(sh - {2'b00, d_reg});
                r_next = trial;
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end else begin
                r_next = sh[DEN_W:0];
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy = (cnt_reg != '0);
    assign quot = q_reg;
endmodule

// ----- rtl/core/scanline_polygon_span_fill_core.sv -----
// Top level of the scanline polygon span fill core (even-odd rule).
//  channel | dir | tdata (low bit up)                      | tuser / tlast
//  s_      | in  | vertex_x[9:0], vertex_y[19:10]          | tuser=kind, no tlast
//  m_      | out | scan_y, x_left, x_right, has_span, done  | tlast=last
// Load, clear and unused-kind words are taken in idle, where s_tready stays high.
// The first row step builds the edge table: each vertex is read, ordered by y and written,
// with a wait on the bit-serial slope divider (26 quotient bits) for each sloped edge.
// Each row walks the edge slots, checks for the end, inserts each crossing by insertion
// sort and emits its output words; the output register holds a word while m_tready is
// low, and s_tready stays low until the item is finished.
// Synchronous active-low reset clears counts, valid bits and control state.
`include "scanline_polygon_span_fill_core_defines.svh"
module scanline_polygon_span_fill_core
    import spf_pkg::*;
#(
    parameter int MAX_VERTICES = 16,
    parameter int COORD_BITS   = 10,
    parameter int FRAC_BITS    = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_tdata,  // vertex_x, vertex_y
    input  logic [1:0]              s_tuser,  // kind
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [((3*COORD_BITS+9)/8)*8-1:0] m_tdata, // scan_y, x_left, x_right, has_span, done_res
    output logic                    m_tlast   // last
);
    localparam int CW  = COORD_BITS;
    localparam int XW  = COORD_BITS + FRAC_BITS;
    localparam int SW  = XW + 1;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int NUMW = CW + FRAC_BITS;
    localparam int MDW = ((3*COORD_BITS+9)/8)*8;
    localparam logic [XW-1:0] XMAX = {XW{1'b1}};
    localparam logic [XW-1:0] HALF = XW'(1) << (FRAC_BITS - 1);

    // Vertex and edge stores.
    logic [CW-1:0] vx_mem [MAX_VERTICES];
    logic [CW-1:0] vy_mem [MAX_VERTICES];
    logic [CW-1:0] lo_mem [MAX_VERTICES];
    logic [CW-1:0] hi_mem [MAX_VERTICES];
    logic [XW-1:0] x_mem  [MAX_VERTICES];
    logic [SW-1:0] st_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] ev_reg;
    logic [CW-1:0] cr_mem [MAX_VERTICES];

    spf_state_t state_reg, state_next;
    logic [NW-1:0] vcnt_reg;
    logic          built_reg;
    logic [CW:0]   row_reg;
    logic [CW-1:0] end_reg;
    logic          any_reg;
    logic [IW-1:0] idx_reg;
    logic [NW-1:0] ncr_reg;
    logic [NW-1:0] emit_reg;
    logic [IW-1:0] ins_reg;
    logic          inserting_reg;
    logic [CW-1:0] c_reg;
    logic [NW-1:0] kcnt_reg;
    // Build temporaries.
    logic [CW-1:0] xa_reg, ya_reg, xb_reg, yb_reg;
    logic [CW-1:0] lo_reg, hi_reg, xl_reg;
    logic          neg_reg;

    // Output register.
    logic          mv_reg;
    logic [3*CW+1:0] md_reg;
    logic          ml_reg;

    logic          acc;
    assign acc = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = MDW'(md_reg);
    assign m_tlast  = ml_reg;

    // Divider: operands taken straight from the fetched endpoints.
    spf_div_ctl_t    dctl;
    logic            dbusy;
    logic [NUMW-1:0] dquot;
    logic [NUMW-1:0] dnum;
    logic [CW-1:0]   dden;
    logic [CW-1:0]   dy;
    logic [CW-1:0]   adx;
    assign dy   = (ya_reg < yb_reg) ? (yb_reg - ya_reg) : (ya_reg - yb_reg);
    assign adx  = (xa_reg < xb_reg) ? (xb_reg - xa_reg) : (xa_reg - xb_reg);
    assign dnum = ({adx, FRAC_BITS'(0)}) + NUMW'(dy >> 1);
    assign dden = dy;
    assign dctl.start = (state_reg == ST_BUILD_EDGE) && (ya_reg != yb_reg);

    spf_divider #(.NUM_W(NUMW), .DEN_W(CW)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl), .num(dnum), .den(dden),
        .busy(dbusy), .quot(dquot)
    );

    logic [IW-1:0] nxt_idx;
    assign nxt_idx = ((NW'(idx_reg) + 1'b1) < vcnt_reg) ? IW'(idx_reg + 1'b1) : '0;
    logic last_idx;
    assign last_idx = (NW'(idx_reg) == NW'(MAX_VERTICES - 1));

    // Current edge fields.
    logic [CW-1:0] e_lo, e_hi;
    logic [XW-1:0] e_x;
    logic [SW-1:0] e_st;
    logic          e_act;
    logic [XW:0]   rnd;
    logic [CW-1:0] rc;
    logic signed [XW+1:0] nx;
    assign e_lo = lo_mem[idx_reg];
    assign e_hi = hi_mem[idx_reg];
    assign e_x  = x_mem[idx_reg];
    assign e_st = st_mem[idx_reg];
    assign e_act = ev_reg[idx_reg] && ({1'b0, e_lo} <= row_reg) &&
                   ((row_reg < {1'b0, e_hi}) ||
                    ((row_reg == {1'b0, end_reg}) && (e_hi == end_reg)));
    assign rnd = {1'b0, e_x} + {1'b0, HALF};
    assign rc  = (rnd[XW:FRAC_BITS] > (XW-FRAC_BITS+1)'({CW{1'b1}})) ? {CW{1'b1}}
                 : CW'(rnd[XW:FRAC_BITS]);
    assign nx  = $signed({2'b00, e_x}) + $signed({e_st[SW-1], e_st});

    logic [CW-1:0] cl, cr_v;
    logic          odd_end;
    assign cl      = cr_mem[IW'(emit_reg)];
    assign odd_end = (emit_reg + 1'b1) >= ncr_reg;
    assign cr_v    = odd_end ? cl : cr_mem[IW'(emit_reg + 1'b1)];

    // Insertion finishes this cycle.
    logic          ins_place;
    assign ins_place = inserting_reg && !(ins_reg != '0 && cr_mem[ins_reg - 1'b1] > c_reg);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc && s_tuser == KIND_ROW) begin
                    state_next = built_reg ? ST_END_SCAN : ST_BUILD_RD;
                end
            end
            ST_BUILD_RD:   state_next = (vcnt_reg == '0) ? ST_END_SCAN : ST_BUILD_EDGE;
            ST_BUILD_EDGE: state_next = (ya_reg == yb_reg) ? ST_BUILD_WR : ST_DIV_WAIT;
            ST_DIV_WAIT:   state_next = dbusy ? ST_DIV_WAIT : ST_BUILD_WR;
            ST_BUILD_WR: begin
                state_next = (NW'(idx_reg) + 1'b1 >= vcnt_reg) ? ST_END_SCAN : ST_BUILD_RD;
            end
            ST_END_SCAN:  state_next = last_idx ? ST_CHECK : ST_END_SCAN;
            ST_CHECK: begin
                state_next = (!any_reg || row_reg > {1'b0, end_reg}) ? ST_DONE_OUT
                                                                     : ST_ROW_SCAN;
            end
            ST_ROW_SCAN: begin
                if ((ins_place && last_idx) || (!inserting_reg && last_idx && !e_act)) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:      state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: begin
                if (!mv_reg || m_tready) begin
                    if (ml_reg) begin
                        state_next = md_reg[3*CW+1] ? ST_IDLE : ST_UPDATE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_UPDATE:    state_next = last_idx ? ST_IDLE : ST_UPDATE;
            ST_DONE_OUT:  state_next = ST_EMIT_WAIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcnt_reg      <= '0;
            built_reg     <= 1'b0;
            row_reg       <= '0;
            ev_reg        <= '0;
            idx_reg       <= '0;
            any_reg       <= 1'b0;
            inserting_reg <= 1'b0;
            mv_reg        <= 1'b0;
            ml_reg        <= 1'b0;
            ncr_reg       <= '0;
            emit_reg      <= '0;
            kcnt_reg      <= '0;
        end else begin
            if (mv_reg && m_tready) mv_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    idx_reg <= '0;
                    any_reg <= 1'b0;
                    if (acc) begin
                        if (s_tuser == KIND_LOAD) begin
                            if (!built_reg && vcnt_reg < NW'(MAX_VERTICES)) begin
                                vx_mem[IW'(vcnt_reg)] <= s_tdata[CW-1:0];
                                vy_mem[IW'(vcnt_reg)] <= s_tdata[2*CW-1:CW];
                                vcnt_reg <= vcnt_reg + 1'b1;
                            end
                        end else if (s_tuser == KIND_CLEAR) begin
                            vcnt_reg  <= '0;
                            built_reg <= 1'b0;
                            row_reg   <= '0;
                            ev_reg    <= '0;
                        end
                        if (s_tuser == KIND_ROW && !built_reg) begin
                            ev_reg  <= '0;
                            row_reg <= {1'b0, {CW{1'b1}}};
                        end
                    end
                end
                ST_BUILD_RD: begin
                    xa_reg <= vx_mem[idx_reg];
                    ya_reg <= vy_mem[idx_reg];
                    xb_reg <= vx_mem[nxt_idx];
                    yb_reg <= vy_mem[nxt_idx];
                end
                ST_BUILD_EDGE: begin
                    // Order endpoints by y; xa_reg keeps the upper x.
                    if (ya_reg < yb_reg) begin
                        lo_reg <= ya_reg; hi_reg <= yb_reg; xl_reg <= xa_reg;
                        xa_reg <= xb_reg; neg_reg <= (xb_reg < xa_reg);
                    end else begin
                        lo_reg <= yb_reg; hi_reg <= ya_reg; xl_reg <= xb_reg;
                        neg_reg <= (xa_reg < xb_reg);
                    end
                end
                ST_BUILD_WR: begin
                    if (ya_reg != yb_reg) begin
                        lo_mem[idx_reg] <= lo_reg;
                        hi_mem[idx_reg] <= hi_reg;
                        x_mem[idx_reg]  <= {xl_reg, FRAC_BITS'(0)};
                        st_mem[idx_reg] <= neg_reg ? SW'(-$signed({1'b0, dquot}))
                                                   : SW'(dquot);
                        ev_reg[idx_reg] <= 1'b1;
                        if ({1'b0, lo_reg} < row_reg) row_reg <= {1'b0, lo_reg};
                    end
                    if (NW'(idx_reg) + 1'b1 >= vcnt_reg) begin
                        built_reg <= 1'b1;
                        idx_reg   <= '0;
                        if (row_reg == {1'b0, {CW{1'b1}}} && ya_reg == yb_reg
                            && ev_reg == '0) row_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_END_SCAN: begin
                    built_reg <= 1'b1;
                    if (ev_reg[idx_reg]) begin
                        if (!any_reg || e_hi > end_reg) end_reg <= e_hi;
                        any_reg <= 1'b1;
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                end
                ST_CHECK: begin
                    ncr_reg       <= '0;
                    inserting_reg <= 1'b0;
                    idx_reg       <= '0;
                end
                ST_ROW_SCAN: begin
                    // Insertion sort: one shift step per cycle.
                    if (inserting_reg) begin
                        if (ins_reg != '0 && cr_mem[ins_reg - 1'b1] > c_reg) begin
                            cr_mem[ins_reg] <= cr_mem[ins_reg - 1'b1];
                            ins_reg <= ins_reg - 1'b1;
                        end else begin
                            cr_mem[ins_reg] <= c_reg;
                            ncr_reg <= ncr_reg + 1'b1;
                            inserting_reg <= 1'b0;
                            idx_reg <= last_idx ? idx_reg : idx_reg + 1'b1;
                            if (last_idx) idx_reg <= '0;
                        end
                    end else if (e_act && !(last_idx && ncr_reg == NW'(MAX_VERTICES))) begin
                        c_reg <= rc;
                        ins_reg <= IW'(ncr_reg);
                        inserting_reg <= 1'b1;
                    end else begin
                        idx_reg <= last_idx ? '0 : idx_reg + 1'b1;
                    end
                    emit_reg <= '0;
                    kcnt_reg <= '0;
                end
                ST_EMIT: begin
                    mv_reg <= 1'b1;
                    if (ncr_reg == '0) begin
                        md_reg <= {2'b00, {CW{1'b0}}, {CW{1'b0}}, row_reg[CW-1:0]};
                        ml_reg <= 1'b1;
                    end else begin
                        md_reg <= {2'b01, cr_v, cl, row_reg[CW-1:0]};
                        ml_reg <= ((emit_reg + 2'd2) >= ncr_reg) ||
                                  (kcnt_reg == NW'(MAX_SPANS - 1));
                        emit_reg <= emit_reg + 2'd2;
                        kcnt_reg <= kcnt_reg + 1'b1;
                    end
                end
                ST_EMIT_WAIT: begin
                    if ((!mv_reg || m_tready) && ml_reg) begin
                        idx_reg <= '0;
                        if (md_reg[3*CW+1]) ml_reg <= 1'b0;
                    end
                end
                ST_UPDATE: begin
                    if (e_act) begin
                        if (nx < 0) x_mem[idx_reg] <= '0;
                        else if (nx > $signed({2'b00, XMAX})) x_mem[idx_reg] <= XMAX;
                        else x_mem[idx_reg] <= XW'(nx);
                    end
                    if (last_idx) begin
                        row_reg <= row_reg + 1'b1;
                        ml_reg  <= 1'b0;
                        idx_reg <= '0;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DONE_OUT: begin
                    mv_reg <= 1'b1;
                    md_reg <= {2'b10, {(3*CW){1'b0}}};
                    ml_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    `SPF_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_tready, !mv_reg || state_reg == ST_IDLE, "ready outside idle")
    `SPF_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word dropped")
    `SPF_ASSERT_IMP(a_cnt, aclk, aresetn, 1'b1, vcnt_reg <= NW'(MAX_VERTICES), "vertex count overflow")
endmodule
